FILE: sv/ssvs_pkg.sv
// shared types and constants for the sorted sparse vector store
// no dependencies; every other file but ssvs_ram refers to this package by scoped names

package ssvs_pkg;

    localparam int CAPACITY  = 256;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SRCH_W    = CNT_W + 1;
    localparam int IDX_W     = 31;
    localparam int VAL_W     = 64;
    localparam int MODE_W    = 2;
    localparam int OUT_CNT_W = 9;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_SET    = 2'd1,
        MODE_APPEND = 2'd2
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  feat_key;
        logic [VAL_W-1:0]  value_word;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic                 found;
        logic                 status;
        logic [OUT_CNT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PROBE,
        OP_NARROW,
        OP_HIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_UPDATE,
        OP_MARK,
        OP_FULL,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_INSERT,
        OP_APPEND,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic srch_empty;
        logic key_eq;
        logic key_lt;
        logic scan_end;
        logic shift_done;
        logic full;
        logic rsp_busy;
    } dp_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND,
        ST_FINISH
    } state_t;

endpackage

FILE: sv/ssvs_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies

module ssvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/ssvs_ctrl.sv
// control state machine: sequences search, scan, shift and write steps
// depends on ssvs_pkg

module ssvs_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic [ssvs_pkg::MODE_W-1:0] mode,
    input  ssvs_pkg::dp_sts_t        sts,
    output ssvs_pkg::dp_op_t         op,
    output logic                     cmd_stall
);

    ssvs_pkg::state_t state_reg;
    ssvs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssvs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = ssvs_pkg::OP_NONE;
        cmd_stall  = 1'b1;
        unique case (state_reg)
            ssvs_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    op = ssvs_pkg::OP_LOAD;
                    unique case (mode)
                        ssvs_pkg::MODE_LOOKUP: state_next = ssvs_pkg::ST_PROBE;
                        ssvs_pkg::MODE_SET:    state_next = ssvs_pkg::ST_SCAN_RD;
                        ssvs_pkg::MODE_APPEND: state_next = ssvs_pkg::ST_APPEND;
                        default:               state_next = ssvs_pkg::ST_FINISH;
                    endcase
                end
            end
            ssvs_pkg::ST_PROBE:
            begin
                if (sts.srch_empty)
                begin
                    state_next = ssvs_pkg::ST_FINISH;
                end
                else
                begin
                    op         = ssvs_pkg::OP_PROBE;
                    state_next = ssvs_pkg::ST_COMPARE;
                end
            end
            ssvs_pkg::ST_COMPARE:
            begin
                if (sts.key_eq)
                begin
                    op         = ssvs_pkg::OP_HIT;
                    state_next = ssvs_pkg::ST_FINISH;
                end
                else
                begin
                    op         = ssvs_pkg::OP_NARROW;
                    state_next = ssvs_pkg::ST_PROBE;
                end
            end
            ssvs_pkg::ST_SCAN_RD:
            begin
                priority if (!sts.scan_end)
                begin
                    op         = ssvs_pkg::OP_SCAN_RD;
                    state_next = ssvs_pkg::ST_SCAN_CMP;
                end
                else if (sts.full)
                begin
                    op         = ssvs_pkg::OP_FULL;
                    state_next = ssvs_pkg::ST_FINISH;
                end
                else
                begin
                    op         = ssvs_pkg::OP_MARK;
                    state_next = ssvs_pkg::ST_SHIFT_RD;
                end
            end
            ssvs_pkg::ST_SCAN_CMP:
            begin
                priority if (sts.key_eq)
                begin
                    op         = ssvs_pkg::OP_UPDATE;
                    state_next = ssvs_pkg::ST_FINISH;
                end
                else if (sts.key_lt)
                begin
                    op         = ssvs_pkg::OP_SCAN_NEXT;
                    state_next = ssvs_pkg::ST_SCAN_RD;
                end
                else if (sts.full)
                begin
                    op         = ssvs_pkg::OP_FULL;
                    state_next = ssvs_pkg::ST_FINISH;
                end
                else
                begin
                    op         = ssvs_pkg::OP_MARK;
                    state_next = ssvs_pkg::ST_SHIFT_RD;
                end
            end
            ssvs_pkg::ST_SHIFT_RD:
            begin
                if (sts.shift_done)
                begin
                    op         = ssvs_pkg::OP_INSERT;
                    state_next = ssvs_pkg::ST_FINISH;
                end
                else
                begin
                    op         = ssvs_pkg::OP_SHIFT_RD;
                    state_next = ssvs_pkg::ST_SHIFT_WR;
                end
            end
            ssvs_pkg::ST_SHIFT_WR:
            begin
                op         = ssvs_pkg::OP_SHIFT_WR;
                state_next = ssvs_pkg::ST_SHIFT_RD;
            end
            ssvs_pkg::ST_APPEND:
            begin
                op         = sts.full ? ssvs_pkg::OP_FULL : ssvs_pkg::OP_APPEND;
                state_next = ssvs_pkg::ST_FINISH;
            end
            ssvs_pkg::ST_FINISH:
            begin
                if (!sts.rsp_busy)
                begin
                    op         = ssvs_pkg::OP_EMIT;
                    state_next = ssvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssvs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/ssvs_dp.sv
// datapath: table memories, search bounds, scan pointer, entry count, result register
// depends on ssvs_pkg and ssvs_ram

module ssvs_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ssvs_pkg::cmd_t    cmd,
    input  ssvs_pkg::dp_op_t  op,
    input  logic              rsp_stall,
    output ssvs_pkg::dp_sts_t sts,
    output logic              rsp_valid,
    output ssvs_pkg::rsp_t    rsp
);

    localparam int ADDR_W = ssvs_pkg::ADDR_W;
    localparam int CNT_W  = ssvs_pkg::CNT_W;
    localparam int SRCH_W = ssvs_pkg::SRCH_W;
    localparam int IDX_W  = ssvs_pkg::IDX_W;
    localparam int VAL_W  = ssvs_pkg::VAL_W;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic signed [SRCH_W-1:0] low_reg, low_next;
    logic signed [SRCH_W-1:0] high_reg, high_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic [IDX_W-1:0]         key_reg, key_next;
    logic [VAL_W-1:0]         val_reg, val_next;
    logic [VAL_W-1:0]         rvalue_reg, rvalue_next;
    logic                     found_reg, found_next;
    logic                     status_reg, status_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    ssvs_pkg::rsp_t           rsp_reg, rsp_next;

    logic signed [SRCH_W:0]   bound_sum;
    logic signed [SRCH_W-1:0] mid_ext;
    logic [CNT_W-1:0]         ptr_dec;

    logic                     idx_we, val_we, rd_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [IDX_W-1:0]         idx_wd, idx_rd;
    logic [VAL_W-1:0]         val_wd, val_rd;

    // halving search midpoint, only used while low <= high so the sum is non-negative
    assign bound_sum = (SRCH_W+1)'(low_reg) + (SRCH_W+1)'(high_reg);
    assign mid_ext   = {{(SRCH_W-ADDR_W){1'b0}}, mid_reg};
    assign ptr_dec   = ptr_reg - 1'b1;

    ssvs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ssvs_pkg::CAPACITY)
    ) u_index_ram (
        .clk     (clk),
        .wr_en   (idx_we),
        .wr_addr (wr_addr),
        .wr_data (idx_wd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (idx_rd)
    );

    ssvs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ssvs_pkg::CAPACITY)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (wr_addr),
        .wr_data (val_wd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (val_rd)
    );

    always_comb
    begin
        sts.srch_empty = low_reg > high_reg;
        sts.key_eq     = idx_rd == key_reg;
        sts.key_lt     = idx_rd < key_reg;
        sts.scan_end   = ptr_reg == count_reg;
        sts.shift_done = ptr_reg == pos_reg;
        sts.full       = count_reg == CNT_W'(ssvs_pkg::CAPACITY);
        sts.rsp_busy   = rsp_valid_reg && rsp_stall;
    end

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        rvalue_next    = rvalue_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        idx_we         = 1'b0;
        val_we         = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = ptr_reg[ADDR_W-1:0];
        rd_addr        = ptr_reg[ADDR_W-1:0];
        idx_wd         = idx_rd;
        val_wd         = val_rd;
        unique case (op)
            ssvs_pkg::OP_NONE:
            begin
            end
            ssvs_pkg::OP_LOAD:
            begin
                key_next    = cmd.feat_key;
                val_next    = cmd.value_word;
                low_next    = '0;
                high_next   = $signed({1'b0, count_reg}) - 1'b1;
                ptr_next    = '0;
                rvalue_next = '0;
                found_next  = 1'b0;
                status_next = ssvs_pkg::STATUS_OK;
            end
            ssvs_pkg::OP_PROBE:
            begin
                rd_en    = 1'b1;
                rd_addr  = bound_sum[ADDR_W:1];
                mid_next = bound_sum[ADDR_W:1];
            end
            ssvs_pkg::OP_NARROW:
            begin
                if (idx_rd < key_reg)
                begin
                    low_next = mid_ext + 1'b1;
                end
                else
                begin
                    high_next = mid_ext - 1'b1;
                end
            end
            ssvs_pkg::OP_HIT:
            begin
                found_next  = 1'b1;
                rvalue_next = val_rd;
            end
            ssvs_pkg::OP_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            ssvs_pkg::OP_SCAN_NEXT:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            ssvs_pkg::OP_UPDATE:
            begin
                val_we     = 1'b1;
                val_wd     = val_reg;
                found_next = 1'b1;
            end
            ssvs_pkg::OP_MARK:
            begin
                pos_next = ptr_reg;
                ptr_next = count_reg;
            end
            ssvs_pkg::OP_FULL:
            begin
                status_next = ssvs_pkg::STATUS_FULL;
            end
            ssvs_pkg::OP_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_dec[ADDR_W-1:0];
            end
            ssvs_pkg::OP_SHIFT_WR:
            begin
                idx_we   = 1'b1;
                val_we   = 1'b1;
                ptr_next = ptr_dec;
            end
            ssvs_pkg::OP_INSERT:
            begin
                idx_we     = 1'b1;
                val_we     = 1'b1;
                wr_addr    = pos_reg[ADDR_W-1:0];
                idx_wd     = key_reg;
                val_wd     = val_reg;
                count_next = count_reg + 1'b1;
            end
            ssvs_pkg::OP_APPEND:
            begin
                idx_we     = 1'b1;
                val_we     = 1'b1;
                wr_addr    = count_reg[ADDR_W-1:0];
                idx_wd     = key_reg;
                val_wd     = val_reg;
                count_next = count_reg + 1'b1;
            end
            ssvs_pkg::OP_EMIT:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.read_value  = rvalue_reg;
                rsp_next.found       = found_reg;
                rsp_next.status      = status_reg;
                rsp_next.entry_count = ssvs_pkg::OUT_CNT_W'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        rvalue_reg <= rvalue_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ssvs_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("entry count moved by other than one");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        op == ssvs_pkg::OP_EMIT |=> rsp_valid_reg)
        else $error("result word not presented after emit");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == ssvs_pkg::OP_EMIT |-> !(rsp_valid_reg && rsp_stall))
        else $error("result word overwritten while stalled");

endmodule

FILE: sv/sorted_sparse_vector_store_unit.sv
// Sorted sparse vector store: a table of up to 256 (feature index, value) entries
// in two memories with one write and one read port each, driven by a control state
// machine. One command word is worked on at a time. A lookup is a halving search
// in which each probe is a registered memory read, then a compare. A set scans
// from the front entry by entry and, on insert, moves each later entry up one
// place. The result register lets a new command word be taken while the previous
// result word is still stalled. No clearing pass is needed after reset: only
// entries below the entry count are ever read.
// depends on ssvs_pkg, ssvs_ctrl, ssvs_dp

module sorted_sparse_vector_store_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  ssvs_pkg::cmd_t   cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ssvs_pkg::rsp_t   rsp
);

    ssvs_pkg::dp_op_t  op;
    ssvs_pkg::dp_sts_t sts;

    ssvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .mode      (cmd.mode),
        .sts       (sts),
        .op        (op),
        .cmd_stall (cmd_stall)
    );

    ssvs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (op),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

FILE: tb/sorted_sparse_vector_store_check.sv
// checker for the sorted sparse vector store: keeps its own copy of the entry table,
// works out one result word per accepted command word and compares them in order
// depends on ssvs_pkg

module sorted_sparse_vector_store_check (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  ssvs_pkg::cmd_t cmd,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  ssvs_pkg::rsp_t rsp,
    output int             fails,
    output int             pending
);

    logic [ssvs_pkg::IDX_W-1:0] key_tbl [ssvs_pkg::CAPACITY];
    logic [ssvs_pkg::VAL_W-1:0] val_tbl [ssvs_pkg::CAPACITY];
    int                         entries    = 0;
    int                         fail_tally = 0;
    ssvs_pkg::rsp_t             awaited_rsps [$];
    ssvs_pkg::rsp_t             oldest;

    function automatic ssvs_pkg::rsp_t table_update(ssvs_pkg::cmd_t w);
        ssvs_pkg::rsp_t r;
        int             lo;
        int             hi;
        int             mid;
        int             pos;
        logic           stop;
        r = '0;
        r.status = ssvs_pkg::STATUS_OK;
        case (w.mode)
            ssvs_pkg::MODE_LOOKUP:
            begin
                // halving search, first probe at the middle of the filled part
                lo  = 0;
                hi  = entries - 1;
                mid = hi / 2;
                while (lo <= hi && !r.found)
                begin
                    if (key_tbl[mid] < w.feat_key)
                        lo = mid + 1;
                    else if (key_tbl[mid] > w.feat_key)
                        hi = mid - 1;
                    else
                    begin
                        r.read_value = val_tbl[mid];
                        r.found      = 1'b1;
                    end
                    mid = (hi + lo) / 2;
                end
            end
            ssvs_pkg::MODE_SET:
            begin
                // front scan: first equal key is overwritten, else insert before first larger
                pos  = 0;
                stop = 1'b0;
                while (pos < entries && !stop)
                begin
                    if (key_tbl[pos] == w.feat_key)
                    begin
                        val_tbl[pos] = w.value_word;
                        r.found      = 1'b1;
                        stop         = 1'b1;
                    end
                    else if (key_tbl[pos] > w.feat_key)
                        stop = 1'b1;
                    else
                        pos++;
                end
                if (!r.found)
                begin
                    if (entries >= ssvs_pkg::CAPACITY)
                        r.status = ssvs_pkg::STATUS_FULL;
                    else
                    begin
                        for (int i = entries; i > pos; i--)
                        begin
                            key_tbl[i] = key_tbl[i-1];
                            val_tbl[i] = val_tbl[i-1];
                        end
                        key_tbl[pos] = w.feat_key;
                        val_tbl[pos] = w.value_word;
                        entries++;
                    end
                end
            end
            ssvs_pkg::MODE_APPEND:
            begin
                if (entries >= ssvs_pkg::CAPACITY)
                    r.status = ssvs_pkg::STATUS_FULL;
                else
                begin
                    key_tbl[entries] = w.feat_key;
                    val_tbl[entries] = w.value_word;
                    entries++;
                end
            end
            default:
                r.read_value = '0;
        endcase
        r.entry_count = entries[ssvs_pkg::OUT_CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries    = 0;
            fail_tally = 0;
            awaited_rsps.delete();
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                awaited_rsps.push_back(table_update(cmd));
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    $display("%0t unexpected result word: expected none, actual %h", $time, rsp);
                    fail_tally++;
                end
                else
                begin
                    oldest = awaited_rsps.pop_front();
                    check_field("read_value", oldest.read_value, rsp.read_value);
                    check_field("found", 64'(oldest.found), 64'(rsp.found));
                    check_field("status", 64'(oldest.status), 64'(rsp.status));
                    check_field("entry_count", 64'(oldest.entry_count),
                                64'(rsp.entry_count));
                end
            end
            pending <= awaited_rsps.size();
            fails   <= fail_tally;
        end
    end

endmodule

FILE: tb/sorted_sparse_vector_store_unit_test.sv
// top of the sorted sparse vector store testbench: clock, reset, command words
// and result stalls, verdict; checking is left to sorted_sparse_vector_store_check
// depends on ssvs_pkg, sorted_sparse_vector_store_unit, sorted_sparse_vector_store_check

module sorted_sparse_vector_store_unit_test;

    localparam logic [ssvs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 600;
    localparam int HOLD_START  = 3000;
    localparam int HOLD_CYCLES = 400;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cmd_valid;
    logic                       cmd_stall;
    ssvs_pkg::cmd_t             cmd;
    logic                       rsp_valid;
    logic                       rsp_stall;
    ssvs_pkg::rsp_t             rsp;
    int                         fails;
    int                         pending;
    int                         cycles    = 0;
    logic                       quiet     = 1'b0;
    logic                       held_long = 1'b0;
    int                         stall_len;
    logic [ssvs_pkg::IDX_W-1:0] append_key = 31'd4096;
    logic [ssvs_pkg::IDX_W-1:0] written_keys [$];
    logic [ssvs_pkg::IDX_W-1:0] max_key = '1;

    sorted_sparse_vector_store_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sorted_sparse_vector_store_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .fails     (fails),
        .pending   (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ssvs_pkg::IDX_W-1:0] pick_key();
        int                         r;
        logic [ssvs_pkg::IDX_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 45 && written_keys.size() > 0)
            return written_keys[$urandom_range(0, written_keys.size() - 1)];
        if (r < 85)
            k = ssvs_pkg::IDX_W'($urandom_range(0, 4095));
        else if (r < 90)
            k = {ssvs_pkg::IDX_W{r[0]}};
        else
            k = ssvs_pkg::IDX_W'($urandom);
        return k;
    endfunction

    function automatic logic [ssvs_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ssvs_pkg::MODE_W-1:0] pick_mode(int lookup_pct, int set_pct,
                                                                int append_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < lookup_pct)
            return ssvs_pkg::MODE_LOOKUP;
        if (r < lookup_pct + set_pct)
            return ssvs_pkg::MODE_SET;
        if (r < lookup_pct + set_pct + append_pct)
            return ssvs_pkg::MODE_APPEND;
        return MODE_SPARE;
    endfunction

    function automatic ssvs_pkg::cmd_t make_word(logic [ssvs_pkg::MODE_W-1:0] m,
                                                 logic [ssvs_pkg::IDX_W-1:0]  k,
                                                 logic [ssvs_pkg::VAL_W-1:0]  v);
        ssvs_pkg::cmd_t w;
        w.mode       = m;
        w.feat_key   = k;
        w.value_word = v;
        return w;
    endfunction

    task automatic send_word(ssvs_pkg::cmd_t w);
        int n;
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        n = quiet ? 0 : gap_len();
        if (n > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic offer_random(int lookup_pct, int set_pct, int append_pct);
        ssvs_pkg::cmd_t w;
        w.mode = pick_mode(lookup_pct, set_pct, append_pct);
        // appends mostly keep the table in order by climbing above the small key band
        if (w.mode == ssvs_pkg::MODE_APPEND && $urandom_range(0, 4) != 0)
        begin
            append_key = ssvs_pkg::IDX_W'(append_key + $urandom_range(1, 16));
            w.feat_key = append_key;
        end
        else
            w.feat_key = pick_key();
        w.value_word = pick_value();
        if (w.mode == ssvs_pkg::MODE_SET || w.mode == ssvs_pkg::MODE_APPEND)
            written_keys.push_back(w.feat_key);
        send_word(w);
    endtask

    task automatic fill_word(int n);
        logic [ssvs_pkg::IDX_W-1:0] k;
        if (n % 2 == 0)
        begin
            k = ssvs_pkg::IDX_W'($urandom);
            send_word(make_word(ssvs_pkg::MODE_SET, k, pick_value()));
        end
        else
        begin
            append_key = ssvs_pkg::IDX_W'(append_key + $urandom_range(1, 16));
            send_word(make_word(ssvs_pkg::MODE_APPEND, append_key, pick_value()));
        end
    endtask

    // result side: random stalls, one long hold-off while words keep coming
    initial
    begin
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_long && cycles >= HOLD_START)
            begin
                held_long = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall_len = quiet ? 0 : gap_len();
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes of key and value, spare mode, out-of-order entries
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, '0, '1));
        send_word(make_word(MODE_SPARE, max_key, '1));
        send_word(make_word(ssvs_pkg::MODE_APPEND, 31'd5, '1));
        send_word(make_word(ssvs_pkg::MODE_SET, max_key, '0));
        send_word(make_word(ssvs_pkg::MODE_SET, '0, 64'ha5a5_5a5a_a5a5_5a5a));
        send_word(make_word(ssvs_pkg::MODE_SET, 31'd5, 64'h0123_4567_89ab_cdef));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, '0, '0));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, 31'd5, '1));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, max_key, '0));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, 31'd3, '0));
        send_word(make_word(ssvs_pkg::MODE_SET, 31'd3, 64'hffff_0000_ffff_0000));
        send_word(make_word(ssvs_pkg::MODE_APPEND, 31'd1, 64'h8000_0000_0000_0001));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, 31'd1, '0));
        send_word(make_word(ssvs_pkg::MODE_SET, 31'd1, 64'h5555_aaaa_5555_aaaa));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, 31'd1, '0));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, 31'd3, '0));
        send_word(make_word(ssvs_pkg::MODE_APPEND, max_key, 64'h7fff_ffff_ffff_fffe));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, max_key, '0));
        send_word(make_word(ssvs_pkg::MODE_SET, max_key, 64'h0000_0001_0000_0001));
        send_word(make_word(MODE_SPARE, '0, '0));
        send_word(make_word(ssvs_pkg::MODE_LOOKUP, 31'd2, '0));
        send_word(make_word(ssvs_pkg::MODE_SET, 31'd2, '1));
        drain();

        // growth: table fills gradually under mixed traffic
        for (int i = 0; i < 1000; i++)
        begin
            quiet = (i % 200) >= 150;
            offer_random(45, 30, 8);
        end
        quiet = 1'b0;
        drain();

        // fresh keys until the table is full and further writes are refused
        for (int i = 0; i < 260; i++)
            fill_word(i);
        drain();

        // full table: overwrites, refused inserts and appends, lookups
        for (int i = 0; i < 600; i++)
        begin
            quiet = (i % 200) >= 150;
            offer_random(40, 35, 15);
        end
        quiet = 1'b0;
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sorted_sparse_vector_store_unit.f
sv/ssvs_pkg.sv
sv/ssvs_ram.sv
sv/ssvs_ctrl.sv
sv/ssvs_dp.sv
sv/sorted_sparse_vector_store_unit.sv
tb/sorted_sparse_vector_store_check.sv
tb/sorted_sparse_vector_store_unit_test.sv
